>>> sv/ptsb_pkg.sv
// Shared types and constants for the periodic timer slot bank.
// No dependencies; every other file refers to it by scoped names.
package ptsb_pkg;

   localparam int SLOTS_DEFAULT = 16;
   localparam int MAX_RESULTS   = 16;

   localparam logic [31:0] TPS_RESET = 32'd1000;

   // millisecond to tick conversion divides by this
   localparam int MS_PER_SECOND = 1000;

   // long division of the 64-bit product by 1000, one 16-bit quotient digit
   // at a time: reciprocal multiply for the digit, then the remainder
   localparam int DIV_DIGIT_W    = 16;
   localparam int DIV_DIGITS     = 4;
   localparam int DIV_REM_W      = 10;
   localparam int MS_RECIP_SHIFT = 36;
   // ceil(2^36 / 1000); exact for every partial dividend below 2^26
   localparam logic [26:0] MS_RECIP = 27'd68719477;

   localparam logic [1:0] MODE_TICK     = 2'd0;
   localparam logic [1:0] MODE_REGISTER = 2'd1;
   localparam logic [1:0] MODE_CANCEL   = 2'd2;

   localparam logic [2:0] KIND_NONE       = 3'd0;
   localparam logic [2:0] KIND_FIRED      = 3'd1;
   localparam logic [2:0] KIND_REGISTERED = 3'd2;
   localparam logic [2:0] KIND_FULL       = 3'd3;
   localparam logic [2:0] KIND_CANCELLED  = 3'd4;

   typedef struct packed {
      logic [1:0]  mode;
      logic [63:0] now;
      logic [31:0] interval_ms;
      logic [3:0]  slot_sel;
   } req_type;

   typedef struct packed {
      logic [3:0] slot_id;
      logic [2:0] event_kind;
      logic       last;
   } rsp_type;

endpackage

>>> sv/ptsb_msdiv.sv
// Millisecond to tick converter: registered 32x32 product, then a divide by
// MS_PER_SECOND one 16-bit digit at a time. Uses ptsb_pkg.
module ptsb_msdiv (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] tps,
   input  logic [31:0] ms,
   output logic        done,
   output logic [63:0] quot
);

   localparam int DW    = ptsb_pkg::DIV_DIGIT_W;
   localparam int REM_W = ptsb_pkg::DIV_REM_W;
   localparam int YW    = REM_W + DW;
   localparam int PW    = ptsb_pkg::MS_RECIP_SHIFT + DW;
   localparam int CNT_W = $clog2(ptsb_pkg::DIV_DIGITS);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic             phase_ff, phase_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [63:0]      work_ff, work_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [DW-1:0]    digit_ff, digit_in;

   logic [63:0]      prod;
   logic [YW-1:0]    part;
   logic [PW-1:0]    qprod;
   logic [YW-1:0]    back;
   logic [YW-1:0]    rem_next;

   assign prod     = {32'd0, tps} * {32'd0, ms};
   // partial dividend: running remainder and the next dividend digit
   assign part     = {rem_ff, work_ff[63 -: DW]};
   assign qprod    = PW'(part) * PW'(ptsb_pkg::MS_RECIP);
   assign back     = YW'(digit_ff) * YW'(ptsb_pkg::MS_PER_SECOND);
   assign rem_next = part - back;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      work_in  = work_ff;
      rem_in   = rem_ff;
      digit_in = digit_ff;
      if (start) begin
         // hold the product; digits start next cycle
         busy_in  = 1'b1;
         phase_in = 1'b0;
         cnt_in   = '0;
         work_in  = prod;
         rem_in   = '0;
      end else if (busy_ff) begin
         if (!phase_ff) begin
            digit_in = qprod[PW-1 -: DW];
            phase_in = 1'b1;
         end else begin
            // shift the quotient digit in as the dividend digit leaves
            rem_in   = rem_next[REM_W-1:0];
            work_in  = {work_ff[63-DW:0], digit_ff};
            phase_in = 1'b0;
            cnt_in   = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(ptsb_pkg::DIV_DIGITS - 1)) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         phase_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff  <= work_in;
      rem_ff   <= rem_in;
      digit_ff <= digit_in;
   end

   assign done = done_ff;
   assign quot = work_ff;

endmodule

>>> sv/periodic_timer_slot_bank_top.sv
// Periodic timer slot bank, top level. Holds the deadline and period
// memories, the slot state machine and the result register.
// Depends on ptsb_pkg and ptsb_msdiv.
//
// A bank of SLOTS periodic timers driven by request words on a valid/ready
// channel; results leave as words on a second valid/ready channel, with
// last marking the final word of each request. Deadlines and periods sit
// in two single-port-write, registered-read memories; the active bits sit
// in flip-flops that reset clears at once, so no clearing pass is needed
// after reset. A tick scans the deadline memory once per fired slot and
// once more to find none left: each pass reads every slot, picks the
// earliest due slot that has not fired on this tick, and re-arms it in
// ST_REARM_RD and ST_REARM_WR. A tick fires at most MAX_RESULTS slots; with
// exactly MAX_RESULTS firings the final empty pass is skipped. A register
// request waits on the divide by 1000 that turns milliseconds into ticks,
// worked through the 64-bit product one 16-bit digit at a time; a full
// table answers with a KIND_FULL word without the divide. Cancel and the
// unused mode answer with one word each. One request is worked on at a
// time; the next is taken while the last result word still waits at the
// output. The ticks-per-second register may be written at any time the
// block is idle and takes effect on the next register request.
module periodic_timer_slot_bank_top #(
   parameter int SLOTS = ptsb_pkg::SLOTS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ptsb_pkg::req_type req_word,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ptsb_pkg::rsp_type rsp_word,
   input  logic              csr_we,
   input  logic [31:0]       csr_wdata
);

   localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int FCW   = $clog2(ptsb_pkg::MAX_RESULTS + 1);
   localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_SCAN     = 6'b000010,
      ST_REARM_RD = 6'b000100,
      ST_REARM_WR = 6'b001000,
      ST_DIV      = 6'b010000,
      ST_WAIT_OUT = 6'b100000
   } state_type;

   // control state
   state_type         state_ff, state_in;
   state_type         after_ff, after_in;
   logic [31:0]       tps_ff, tps_in;
   logic [SLOTS-1:0]  active_ff, active_in;
   logic [SLOTS-1:0]  taken_ff, taken_in;
   logic              rd_go_ff, rd_go_in;
   logic              chk_valid_ff, chk_valid_in;
   logic              best_valid_ff, best_valid_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [FCW-1:0]    fire_cnt_ff, fire_cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // payload
   logic [IW-1:0]     rd_idx_ff, rd_idx_in;
   logic [IW-1:0]     chk_idx_ff, chk_idx_in;
   logic [IW-1:0]     best_idx_ff, best_idx_in;
   logic [63:0]       best_dl_ff, best_dl_in;
   logic [IW-1:0]     pend_idx_ff, pend_idx_in;
   logic [63:0]       now_ff, now_in;
   ptsb_pkg::rsp_type emit_word_ff, emit_word_in;
   ptsb_pkg::rsp_type rsp_word_ff, rsp_word_in;

   // memories
   logic [63:0]       deadline_mem [SLOTS];
   logic [63:0]       period_mem [SLOTS];
   logic [63:0]       dl_rd_ff;
   logic [63:0]       per_rd_ff;
   logic              dl_we, per_we;
   logic [IW-1:0]     dl_waddr;
   logic [63:0]       dl_wdata;

   // divider
   logic              div_start;
   logic              div_done;
   logic [63:0]       div_quot;

   // scan and search
   logic              req_fire;
   logic              take_here;
   logic              pass_end;
   logic              pass_found;
   logic [IW-1:0]     pass_idx;
   logic              free_found;
   logic [IW-1:0]     free_idx;
   logic              out_free;

   ptsb_msdiv u_msdiv (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .tps   (tps_ff),
      .ms    (req_word.interval_ms),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!active_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IW'(i);
         end
      end
   end

   // candidate check on the deadline word read last cycle; strict less-than
   // keeps the lower slot on equal deadlines since the scan goes upward
   assign take_here = chk_valid_ff && active_ff[chk_idx_ff] && !taken_ff[chk_idx_ff]
                      && (dl_rd_ff <= now_ff)
                      && (!best_valid_ff || (dl_rd_ff < best_dl_ff));
   assign pass_end   = chk_valid_ff && (chk_idx_ff == LAST_IDX);
   assign pass_found = best_valid_ff || take_here;
   assign pass_idx   = take_here ? chk_idx_ff : best_idx_ff;

   always_comb begin
      state_in      = state_ff;
      after_in      = after_ff;
      tps_in        = csr_we ? csr_wdata : tps_ff;
      active_in     = active_ff;
      taken_in      = taken_ff;
      rd_go_in      = 1'b0;
      chk_valid_in  = 1'b0;
      best_valid_in = best_valid_ff;
      pend_valid_in = pend_valid_ff;
      fire_cnt_in   = fire_cnt_ff;
      rd_idx_in     = rd_idx_ff;
      chk_idx_in    = rd_idx_ff;
      best_idx_in   = best_idx_ff;
      best_dl_in    = best_dl_ff;
      pend_idx_in   = pend_idx_ff;
      now_in        = now_ff;
      emit_word_in  = emit_word_ff;
      // drop the output word once taken
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_word_in   = rsp_word_ff;
      dl_we         = 1'b0;
      per_we        = 1'b0;
      dl_waddr      = pend_idx_ff;
      dl_wdata      = now_ff + per_rd_ff;
      div_start     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               now_in   = req_word.now;
               after_in = ST_IDLE;
               case (req_word.mode)
                  ptsb_pkg::MODE_TICK: begin
                     taken_in      = '0;
                     fire_cnt_in   = '0;
                     pend_valid_in = 1'b0;
                     best_valid_in = 1'b0;
                     rd_idx_in     = '0;
                     rd_go_in      = 1'b1;
                     state_in      = ST_SCAN;
                  end
                  ptsb_pkg::MODE_REGISTER: begin
                     if (free_found) begin
                        pend_idx_in = free_idx;
                        div_start   = 1'b1;
                        state_in    = ST_DIV;
                     end else begin
                        emit_word_in = '{4'd0, ptsb_pkg::KIND_FULL, 1'b1};
                        state_in     = ST_WAIT_OUT;
                     end
                  end
                  ptsb_pkg::MODE_CANCEL: begin
                     if (32'(req_word.slot_sel) < 32'(SLOTS)) begin
                        active_in[IW'(req_word.slot_sel)] = 1'b0;
                     end
                     emit_word_in = '{req_word.slot_sel, ptsb_pkg::KIND_CANCELLED, 1'b1};
                     state_in     = ST_WAIT_OUT;
                  end
                  default: begin
                     emit_word_in = '{4'd0, ptsb_pkg::KIND_NONE, 1'b1};
                     state_in     = ST_WAIT_OUT;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            // issue reads up to the last slot, check each word the cycle after its read
            if (rd_go_ff) begin
               rd_idx_in    = rd_idx_ff + IW'(1);
               rd_go_in     = (rd_idx_ff != LAST_IDX);
               chk_valid_in = 1'b1;
            end
            if (take_here) begin
               best_valid_in = 1'b1;
               best_idx_in   = chk_idx_ff;
               best_dl_in    = dl_rd_ff;
            end
            if (pass_end) begin
               if (!pass_found) begin
                  // nothing more due: flush the held word, or a none word, as the last one
                  emit_word_in  = pend_valid_ff
                     ? ptsb_pkg::rsp_type'{4'(pend_idx_ff), ptsb_pkg::KIND_FIRED, 1'b1}
                     : ptsb_pkg::rsp_type'{4'd0, ptsb_pkg::KIND_NONE, 1'b1};
                  pend_valid_in = 1'b0;
                  after_in      = ST_IDLE;
                  state_in      = ST_WAIT_OUT;
               end else begin
                  taken_in[pass_idx] = 1'b1;
                  pend_idx_in        = pass_idx;
                  pend_valid_in      = 1'b1;
                  fire_cnt_in        = fire_cnt_ff + FCW'(1);
                  if (pend_valid_ff) begin
                     emit_word_in = '{4'(pend_idx_ff), ptsb_pkg::KIND_FIRED, 1'b0};
                     after_in     = ST_REARM_RD;
                     state_in     = ST_WAIT_OUT;
                  end else begin
                     state_in = ST_REARM_RD;
                  end
               end
            end
         end

         ST_REARM_RD: begin
            // period of the held slot is read this cycle
            state_in = ST_REARM_WR;
         end

         ST_REARM_WR: begin
            dl_we = 1'b1;
            if (fire_cnt_ff == FCW'(ptsb_pkg::MAX_RESULTS)) begin
               emit_word_in  = '{4'(pend_idx_ff), ptsb_pkg::KIND_FIRED, 1'b1};
               pend_valid_in = 1'b0;
               after_in      = ST_IDLE;
               state_in      = ST_WAIT_OUT;
            end else begin
               best_valid_in = 1'b0;
               rd_idx_in     = '0;
               rd_go_in      = 1'b1;
               state_in      = ST_SCAN;
            end
         end

         ST_DIV: begin
            if (div_done) begin
               dl_we        = 1'b1;
               per_we       = 1'b1;
               dl_wdata     = now_ff + div_quot;
               active_in[pend_idx_ff] = 1'b1;
               emit_word_in = '{4'(pend_idx_ff), ptsb_pkg::KIND_REGISTERED, 1'b1};
               after_in     = ST_IDLE;
               state_in     = ST_WAIT_OUT;
            end
         end

         ST_WAIT_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = emit_word_ff;
               state_in     = after_ff;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         after_ff      <= ST_IDLE;
         tps_ff        <= ptsb_pkg::TPS_RESET;
         active_ff     <= '0;
         taken_ff      <= '0;
         rd_go_ff      <= 1'b0;
         chk_valid_ff  <= 1'b0;
         best_valid_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
         fire_cnt_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         after_ff      <= after_in;
         tps_ff        <= tps_in;
         active_ff     <= active_in;
         taken_ff      <= taken_in;
         rd_go_ff      <= rd_go_in;
         chk_valid_ff  <= chk_valid_in;
         best_valid_ff <= best_valid_in;
         pend_valid_ff <= pend_valid_in;
         fire_cnt_ff   <= fire_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff    <= rd_idx_in;
      chk_idx_ff   <= chk_idx_in;
      best_idx_ff  <= best_idx_in;
      best_dl_ff   <= best_dl_in;
      pend_idx_ff  <= pend_idx_in;
      now_ff       <= now_in;
      emit_word_ff <= emit_word_in;
      rsp_word_ff  <= rsp_word_in;
   end

   // deadline memory: scan reads, re-arm and register write
   always_ff @(posedge clock) begin
      if (dl_we) begin
         deadline_mem[dl_waddr] <= dl_wdata;
      end
      dl_rd_ff <= deadline_mem[rd_idx_ff];
   end

   // period memory: register writes, re-arm reads the held slot
   always_ff @(posedge clock) begin
      if (per_we) begin
         period_mem[pend_idx_ff] <= div_quot;
      end
      per_rd_ff <= period_mem[pend_idx_ff];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // a new request never finds a fired slot still held back
   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> !pend_valid_ff)
      else $error("request accepted with a fired slot still held");

   // the conversion result only lands while a registration waits for it
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider finished outside a registration");

   // firings per tick stay within the result limit
   a_fire_bound: assert property (@(posedge clock) disable iff (reset)
      fire_cnt_ff <= FCW'(ptsb_pkg::MAX_RESULTS))
      else $error("too many firings on one tick");

   // deadline writes happen only on re-arm or registration
   a_dl_write_src: assert property (@(posedge clock) disable iff (reset)
      dl_we |-> ((state_ff == ST_REARM_WR) || (state_ff == ST_DIV)))
      else $error("unexpected deadline write");

endmodule
